// ===== rtl/core/rca_pkg.sv =====
`timescale 1ns / 1ps

package rca_pkg;

    localparam int WORD_BITS_DEF = 64;

    // opcodes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam int PC_W = 6;

    // scratch register file addresses: operands, then temporaries
    localparam logic [3:0] R_A   = 4'd0;
    localparam logic [3:0] R_C   = 4'd1;
    localparam logic [3:0] R_B   = 4'd2;
    localparam logic [3:0] R_D   = 4'd3;
    localparam logic [3:0] R_YRN = 4'd4;
    localparam logic [3:0] R_YRD = 4'd5;
    localparam logic [3:0] R_YIN = 4'd6;
    localparam logic [3:0] R_YID = 4'd7;
    localparam logic [3:0] T0    = 4'd8;
    localparam logic [3:0] T1    = 4'd9;
    localparam logic [3:0] T2    = 4'd10;
    localparam logic [3:0] T3    = 4'd11;
    localparam logic [3:0] T4    = 4'd12;
    localparam logic [3:0] T5    = 4'd13;
    localparam logic [3:0] T6    = 4'd14;
    localparam logic [3:0] T7    = 4'd15;

    // where each program leaves its fractions
    localparam logic [3:0] AS_RN = T2;
    localparam logic [3:0] AS_IN = T3;
    localparam logic [3:0] AS_RD = T4;
    localparam logic [3:0] AS_ID = T5;
    localparam logic [3:0] MD_RN = T6;
    localparam logic [3:0] MD_IN = T7;
    localparam logic [3:0] MD_RD = T4;
    localparam logic [3:0] MD_ID = T4;

    // program entry points
    localparam logic [PC_W-1:0] PC_AS  = 6'd0;
    localparam logic [PC_W-1:0] PC_MUL = 6'd9;
    localparam logic [PC_W-1:0] PC_DIV = 6'd25;

    typedef enum logic [2:0] {
        U_MUL,
        U_ADD,
        U_SUB,
        U_ASB,   // add or subtract, as the opcode says
        U_END
    } ukind_t;

    typedef struct packed {
        ukind_t     kind;
        logic [3:0] dst;
        logic [3:0] sa;
        logic [3:0] sb;
    } uop_t;

    function automatic uop_t mk(ukind_t k, logic [3:0] d, logic [3:0] a, logic [3:0] b);
        uop_t u;
        u.kind = k;
        u.dst  = d;
        u.sa   = a;
        u.sb   = b;
        return u;
    endfunction

    function automatic uop_t urom(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            // add / subtract
            6'd0:  u = mk(U_MUL, T0, R_A, R_YRD);
            6'd1:  u = mk(U_MUL, T1, R_C, R_YRN);
            6'd2:  u = mk(U_ASB, T2, T0, T1);
            6'd3:  u = mk(U_MUL, T0, R_B, R_YID);
            6'd4:  u = mk(U_MUL, T1, R_D, R_YIN);
            6'd5:  u = mk(U_ASB, T3, T0, T1);
            6'd6:  u = mk(U_MUL, T4, R_C, R_YRD);
            6'd7:  u = mk(U_MUL, T5, R_D, R_YID);
            6'd8:  u = mk(U_END, T0, T0, T0);
            // multiply
            6'd9:  u = mk(U_MUL, T0, R_C, R_YRD);
            6'd10: u = mk(U_MUL, T1, R_D, R_YID);
            6'd11: u = mk(U_MUL, T4, T0, T1);
            6'd12: u = mk(U_MUL, T2, R_A, R_YRN);
            6'd13: u = mk(U_MUL, T2, T2, T1);
            6'd14: u = mk(U_MUL, T3, R_B, R_YIN);
            6'd15: u = mk(U_MUL, T3, T3, T0);
            6'd16: u = mk(U_SUB, T6, T2, T3);
            6'd17: u = mk(U_MUL, T2, R_A, R_YIN);
            6'd18: u = mk(U_MUL, T3, R_D, R_YRD);
            6'd19: u = mk(U_MUL, T2, T2, T3);
            6'd20: u = mk(U_MUL, T3, R_C, R_YID);
            6'd21: u = mk(U_MUL, T7, R_B, R_YRN);
            6'd22: u = mk(U_MUL, T3, T7, T3);
            6'd23: u = mk(U_ADD, T7, T2, T3);
            6'd24: u = mk(U_END, T0, T0, T0);
            // divide
            6'd25: u = mk(U_MUL, T0, R_C, R_YRD);
            6'd26: u = mk(U_MUL, T1, R_D, R_YID);
            6'd27: u = mk(U_MUL, T4, T0, T1);
            6'd28: u = mk(U_MUL, T2, R_A, R_YRN);
            6'd29: u = mk(U_MUL, T2, T2, T1);
            6'd30: u = mk(U_MUL, T3, R_B, R_YIN);
            6'd31: u = mk(U_MUL, T3, T3, T0);
            6'd32: u = mk(U_ADD, T6, T2, T3);
            6'd33: u = mk(U_MUL, T2, R_A, R_YIN);
            6'd34: u = mk(U_MUL, T3, R_D, R_YRD);
            6'd35: u = mk(U_MUL, T2, T2, T3);
            6'd36: u = mk(U_MUL, T3, R_C, R_YID);
            6'd37: u = mk(U_MUL, T7, R_B, R_YRN);
            6'd38: u = mk(U_MUL, T3, T7, T3);
            6'd39: u = mk(U_SUB, T7, T3, T2);
            6'd40: u = mk(U_MUL, T0, R_YRD, R_YID);
            6'd41: u = mk(U_MUL, T0, T0, T0);
            6'd42: u = mk(U_MUL, T6, T6, T0);
            6'd43: u = mk(U_MUL, T7, T7, T0);
            6'd44: u = mk(U_MUL, T1, R_YRN, R_YID);
            6'd45: u = mk(U_MUL, T1, T1, T1);
            6'd46: u = mk(U_MUL, T2, R_YIN, R_YRD);
            6'd47: u = mk(U_MUL, T2, T2, T2);
            6'd48: u = mk(U_ADD, T1, T1, T2);
            6'd49: u = mk(U_MUL, T4, T4, T1);
            default: u = mk(U_END, T0, T0, T0);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/rational_complex_alu.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Transfer
// --------  --------------------------------------  ---------------------------
// command   start, op, x_*_num/den, y_*_num/den     edge with start & !busy
// result    done, r_*_num/den, status               the one cycle done is high
//
// The eight operands are loaded into the scratch file from a shift register, then
// each multiply runs on the shift-add multiplier (6 for add/sub, 13 for multiply, 22 for divide).
// Multiply/divide then reduce two fractions on the restoring divider: Euclid
// steps plus two quotients per fraction.
// No clearing pass after reset; the scratch file is written before read.
// The receiver cannot stall: done pulses one cycle, busy drops with it.
module rational_complex_alu #(
    parameter int WORD_BITS = rca_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [63:0] x_re_num,
    input  logic signed [63:0] x_re_den,
    input  logic signed [63:0] x_im_num,
    input  logic signed [63:0] x_im_den,
    input  logic signed [63:0] y_re_num,
    input  logic signed [63:0] y_re_den,
    input  logic signed [63:0] y_im_num,
    input  logic signed [63:0] y_im_den,
    output logic               done,
    output logic signed [63:0] r_re_num,
    output logic signed [63:0] r_re_den,
    output logic signed [63:0] r_im_num,
    output logic signed [63:0] r_im_den,
    output logic               status
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RD, S_EX, S_MUL, S_FETCH, S_FWAIT,
        S_GCHK, S_GDIV, S_QN, S_QD, S_STORE
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 op_reg;
    logic [W-1:0]               in_sh_reg [8];
    logic [2:0]                 load_cnt_reg;
    logic [rca_pkg::PC_W-1:0]   pc_reg;
    logic [CW-1:0]              cnt_reg;
    logic [W-1:0]               mcd_reg, mpl_reg, acc_reg;
    logic [W-1:0]               dd_reg, dv_reg, rem_reg;
    logic [W-1:0]               num_reg, den_reg, gp_reg, gq_reg;
    logic                       pair_reg, bad_reg;
    logic                       done_reg, status_reg;
    logic signed [W-1:0]        res_rn_reg, res_rd_reg, res_in_reg, res_id_reg;

    // scratch register file
    logic [W-1:0]               mem [16];
    logic [W-1:0]               rd_a_reg, rd_b_reg;
    logic                       mem_we;
    logic [3:0]                 mem_waddr, raddr_a, raddr_b;
    logic [W-1:0]               mem_wdata;

    rca_pkg::uop_t              uop;
    logic                       md, last, is_sub;
    logic [W-1:0]               alu, acc_next;
    logic [W:0]                 trial;
    logic                       ge;
    logic [W-1:0]               rem_next, dd_next;
    logic [W-1:0]               fa_mag, fb_mag, num_mag, den_mag;

    assign uop  = rca_pkg::urom(pc_reg);
    assign md   = op_reg[1];
    assign last = (cnt_reg == CW'(W - 1));

    assign is_sub = (uop.kind == rca_pkg::U_SUB)
                 || (uop.kind == rca_pkg::U_ASB && op_reg == rca_pkg::OP_SUB);
    assign alu      = is_sub ? (rd_a_reg - rd_b_reg) : (rd_a_reg + rd_b_reg);
    assign acc_next = acc_reg + (mpl_reg[0] ? mcd_reg : '0);

    // one restoring-division bit per cycle
    assign trial    = {rem_reg, dd_reg[W-1]};
    assign ge       = (trial >= {1'b0, dv_reg});
    assign rem_next = ge ? W'(trial - {1'b0, dv_reg}) : trial[W-1:0];
    assign dd_next  = {dd_reg[W-2:0], ge};

    assign fa_mag  = rd_a_reg[W-1] ? (W'(0) - rd_a_reg) : rd_a_reg;
    assign fb_mag  = rd_b_reg[W-1] ? (W'(0) - rd_b_reg) : rd_b_reg;
    assign num_mag = num_reg[W-1] ? (W'(0) - num_reg) : num_reg;
    assign den_mag = den_reg[W-1] ? (W'(0) - den_reg) : den_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = uop.dst;
        mem_wdata = alu;
        raddr_a   = uop.sa;
        raddr_b   = uop.sb;
        unique case (state_reg)
            S_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, load_cnt_reg};
                mem_wdata = in_sh_reg[0];
            end
            S_EX:
            begin
                mem_we = (uop.kind == rca_pkg::U_ADD) || (uop.kind == rca_pkg::U_SUB)
                      || (uop.kind == rca_pkg::U_ASB);
            end
            S_MUL:
            begin
                mem_we    = last;
                mem_wdata = acc_next;
            end
            S_FETCH:
            begin
                if (md)
                begin
                    raddr_a = pair_reg ? rca_pkg::MD_IN : rca_pkg::MD_RN;
                    raddr_b = pair_reg ? rca_pkg::MD_ID : rca_pkg::MD_RD;
                end
                else
                begin
                    raddr_a = pair_reg ? rca_pkg::AS_IN : rca_pkg::AS_RN;
                    raddr_b = pair_reg ? rca_pkg::AS_ID : rca_pkg::AS_RD;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            load_cnt_reg <= '0;
            pc_reg       <= '0;
            cnt_reg      <= '0;
            pair_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op;
                        in_sh_reg[0] <= x_re_num[W-1:0];
                        in_sh_reg[1] <= x_re_den[W-1:0];
                        in_sh_reg[2] <= x_im_num[W-1:0];
                        in_sh_reg[3] <= x_im_den[W-1:0];
                        in_sh_reg[4] <= y_re_num[W-1:0];
                        in_sh_reg[5] <= y_re_den[W-1:0];
                        in_sh_reg[6] <= y_im_num[W-1:0];
                        in_sh_reg[7] <= y_im_den[W-1:0];
                        load_cnt_reg <= '0;
                        bad_reg      <= 1'b0;
                        pair_reg     <= 1'b0;
                        unique case (op)
                            rca_pkg::OP_MUL: pc_reg <= rca_pkg::PC_MUL;
                            rca_pkg::OP_DIV: pc_reg <= rca_pkg::PC_DIV;
                            default:         pc_reg <= rca_pkg::PC_AS;
                        endcase
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    for (int i = 0; i < 7; i++)
                        in_sh_reg[i] <= in_sh_reg[i+1];
                    load_cnt_reg <= load_cnt_reg + 3'd1;
                    if (load_cnt_reg == 3'd7)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (uop.kind == rca_pkg::U_END)
                        state_reg <= S_FETCH;
                    else
                        state_reg <= S_EX;
                end
                S_EX:
                begin
                    if (uop.kind == rca_pkg::U_MUL)
                    begin
                        mcd_reg   <= rd_a_reg;
                        mpl_reg   <= rd_b_reg;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= acc_next;
                    mcd_reg <= {mcd_reg[W-2:0], 1'b0};
                    mpl_reg <= {1'b0, mpl_reg[W-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_FETCH:
                    state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    num_reg   <= rd_a_reg;
                    den_reg   <= rd_b_reg;
                    gp_reg    <= fa_mag;
                    gq_reg    <= fb_mag;
                    state_reg <= md ? S_GCHK : S_STORE;
                end
                S_GCHK:
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (gq_reg == '0)
                    begin
                        if (gp_reg == '0)
                        begin
                            // 0/0: keep as is, flag it
                            bad_reg   <= 1'b1;
                            state_reg <= S_STORE;
                        end
                        else
                        begin
                            dd_reg    <= num_mag;
                            dv_reg    <= gp_reg;
                            state_reg <= S_QN;
                        end
                    end
                    else
                    begin
                        dd_reg    <= gp_reg;
                        dv_reg    <= gq_reg;
                        state_reg <= S_GDIV;
                    end
                end
                S_GDIV:
                begin
                    dd_reg  <= dd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        gp_reg    <= gq_reg;
                        gq_reg    <= rem_next;
                        state_reg <= S_GCHK;
                    end
                end
                S_QN:
                begin
                    dd_reg  <= dd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        num_reg   <= num_reg[W-1] ? (W'(0) - dd_next) : dd_next;
                        dd_reg    <= den_mag;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_QD;
                    end
                end
                S_QD:
                begin
                    dd_reg  <= dd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        den_reg   <= den_reg[W-1] ? (W'(0) - dd_next) : dd_next;
                        state_reg <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    if (!pair_reg)
                    begin
                        res_rn_reg <= num_reg;
                        res_rd_reg <= den_reg;
                        pair_reg   <= 1'b1;
                        state_reg  <= S_FETCH;
                    end
                    else
                    begin
                        res_in_reg <= num_reg;
                        res_id_reg <= den_reg;
                        status_reg <= bad_reg;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign r_re_num = 64'(res_rn_reg);
    assign r_re_den = 64'(res_rd_reg);
    assign r_im_num = 64'(res_in_reg);
    assign r_im_den = 64'(res_id_reg);

endmodule

// ===== rtl/core/rca_checker.sv =====
`timescale 1ns / 1ps

module rca_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer taken but busy not raised");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

endmodule

bind rational_complex_alu rca_checker u_rca_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// ===== bench/rational_complex_alu_tb.sv =====
`timescale 1ns / 1ps

module rational_complex_alu_tb;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] xrn, xrd, xin, xid, yrn, yrd, yin, yid;
    } cmd_t;

    typedef struct {
        logic [63:0] rn, rd, in_, id;
        logic        st;
    } frac_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic signed [63:0] x_re_num = '0, x_re_den = '0, x_im_num = '0, x_im_den = '0;
    logic signed [63:0] y_re_num = '0, y_re_den = '0, y_im_num = '0, y_im_den = '0;
    logic done;
    logic signed [63:0] r_re_num, r_re_den, r_im_num, r_im_den;
    logic status;

    rational_complex_alu dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .x_re_num(x_re_num), .x_re_den(x_re_den),
        .x_im_num(x_im_num), .x_im_den(x_im_den),
        .y_re_num(y_re_num), .y_re_den(y_re_den),
        .y_im_num(y_im_num), .y_im_den(y_im_den),
        .done(done), .r_re_num(r_re_num), .r_re_den(r_re_den),
        .r_im_num(r_im_num), .r_im_den(r_im_den), .status(status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cmd_t      pending_cmds[$];
    frac_res_t expected_fracs[$];
    int        sender_idle_pct = 0;
    bit        hold_sender = 1'b0;
    bit        accepted = 1'b0;
    int        errors = 0;
    longint    cycles = 0;
    // the worst case for every command plus idling fits easily under this limit
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    // Euclid on magnitudes; a 0/0 fraction is left as is and flagged.
    function automatic bit reduce_frac(inout logic [63:0] num, inout logic [63:0] den);
        logic [63:0] p, q, t;
        p = num[63] ? -num : num;
        q = den[63] ? -den : den;
        while (q != 0)
        begin
            t = p % q;
            p = q;
            q = t;
        end
        if (p == 0)
            return 1'b1;
        num = num[63] ? -((-num) / p) : num / p;
        den = den[63] ? -((-den) / p) : den / p;
        return 1'b0;
    endfunction

    // all products and sums wrap mod 2^64 in 64-bit vectors
    function automatic frac_res_t complex_rational_op(cmd_t c);
        frac_res_t r;
        logic [63:0] den, sq, sc;
        bit bad0, bad1;
        r.st = 1'b0;
        if (c.op == rca_pkg::OP_ADD || c.op == rca_pkg::OP_SUB)
        begin
            if (c.op == rca_pkg::OP_ADD)
            begin
                r.rn  = c.xrn * c.yrd + c.xrd * c.yrn;
                r.in_ = c.xin * c.yid + c.xid * c.yin;
            end
            else
            begin
                r.rn  = c.xrn * c.yrd - c.xrd * c.yrn;
                r.in_ = c.xin * c.yid - c.xid * c.yin;
            end
            r.rd = c.xrd * c.yrd;
            r.id = c.xid * c.yid;
        end
        else
        begin
            den = c.xrd * c.yrd * c.xid * c.yid;
            if (c.op == rca_pkg::OP_MUL)
            begin
                r.rn  = c.xrn * c.yrn * c.xid * c.yid - c.xin * c.yin * c.xrd * c.yrd;
                r.in_ = c.xrn * c.yin * c.xid * c.yrd + c.xin * c.yrn * c.xrd * c.yid;
                r.rd  = den;
            end
            else
            begin
                sq = c.yrn * c.yid * c.yrn * c.yid + c.yin * c.yrd * c.yin * c.yrd;
                sc = c.yrd * c.yid * c.yrd * c.yid;
                r.rn  = (c.xrn * c.yrn * c.xid * c.yid + c.xin * c.yin * c.xrd * c.yrd) * sc;
                r.in_ = ((-c.xrn) * c.yin * c.xid * c.yrd + c.xin * c.yrn * c.xrd * c.yid) * sc;
                r.rd  = den * sq;
            end
            r.id = r.rd;
            bad0 = reduce_frac(r.rn, r.rd);
            bad1 = reduce_frac(r.in_, r.id);
            r.st = bad0 | bad1;
        end
        return r;
    endfunction

    // Driver: changes on falling edge; a new command once the last one was taken.
    always @(negedge clk)
    begin
        cmd_t c;
        if (rst_n)
        begin
            if ((!start || accepted) && !hold_sender && pending_cmds.size() != 0
                && $urandom_range(99) >= sender_idle_pct)
            begin
                c = pending_cmds.pop_front();
                op <= c.op;
                x_re_num <= c.xrn; x_re_den <= c.xrd;
                x_im_num <= c.xin; x_im_den <= c.xid;
                y_re_num <= c.yrn; y_re_den <= c.yrd;
                y_im_num <= c.yin; y_im_den <= c.yid;
                start <= 1'b1;
            end
            else if (accepted)
                start <= 1'b0;
        end
    end

    // Monitor: predict on accepted commands, check on done.
    always @(posedge clk)
    begin
        cmd_t c;
        frac_res_t e;
        cycles <= cycles + 1;
        accepted <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            c.op = op;
            c.xrn = x_re_num; c.xrd = x_re_den; c.xin = x_im_num; c.xid = x_im_den;
            c.yrn = y_re_num; c.yrd = y_re_den; c.yin = y_im_num; c.yid = y_im_den;
            expected_fracs.push_back(complex_rational_op(c));
        end
        if (rst_n && done)
        begin
            if (expected_fracs.size() == 0)
            begin
                $display("%0t: unexpected result %h/%h %h/%h st=%b", $time,
                         r_re_num, r_re_den, r_im_num, r_im_den, status);
                errors++;
            end
            else
            begin
                e = expected_fracs.pop_front();
                if ({r_re_num, r_re_den, r_im_num, r_im_den, status}
                    !== {e.rn, e.rd, e.in_, e.id, e.st})
                begin
                    $display("%0t: expected %h/%h %h/%h st=%b, got %h/%h %h/%h st=%b",
                             $time, e.rn, e.rd, e.in_, e.id, e.st,
                             r_re_num, r_re_den, r_im_num, r_im_den, status);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(9));
            1: v = -$signed(64'($urandom_range(9)));
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7fff_ffff_ffff_ffff;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic push_cmd(logic [1:0] o, logic [63:0] a, b, cc, d, e, f, g, h);
        cmd_t c;
        c.op = o;
        c.xrn = a; c.xrd = b; c.xin = cc; c.xid = d;
        c.yrn = e; c.yrd = f; c.yin = g; c.yid = h;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || expected_fracs.size() != 0)
            @(posedge clk);
    endtask

    localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: every op, extremes, zero gcd, zero denominators
        for (int o = 0; o < 4; o++)
        begin
            push_cmd(2'(o), 1, 2, 3, 4, 5, 6, 7, 8);
            push_cmd(2'(o), MINN, MAXP, MAXP, MINN, MINN, 1, -1, MAXP);
            push_cmd(2'(o), 0, 0, 0, 0, 0, 0, 0, 0);
            push_cmd(2'(o), 6, 0, -4, 3, 2, 5, 0, 1);
            push_cmd(2'(o), -1, -1, -1, -1, -1, -1, -1, -1);
        end
        push_cmd(rca_pkg::OP_DIV, 2, 4, 6, 8, 1, 1, 1, 1);
        wait_drained();

        // one-shot sender pause with a command pending
        hold_sender = 1'b1;
        push_cmd(rca_pkg::OP_MUL, 3, 7, -9, 11, 13, 17, 19, 23);
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 72 : (phase == 3) ? 36 : 0;
            for (int i = 0; i < 50; i++)
                push_cmd(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64(),
                         rand64(), rand64(), rand64(), rand64());
            wait_drained();
        end
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
